/* src/rbs_pkg.sv */
// rbs_pkg: shared constants and types for the range-binned statistics block.
// No dependencies; imported by range_binned_statistics_top and its testbench.
package rbs_pkg;

    // Default build parameters
    localparam int MAX_BINS_DEF    = 64;
    localparam int VALUE_LIMIT_DEF = 3000000;

    // Field widths
    localparam int SAMPLE_W   = 22;
    localparam int QBIN_W     = 6;
    localparam int NBINS_W    = 7;
    localparam int BWIDTH_W   = 22;
    localparam int COUNT_W    = 32;
    localparam int SUM_W      = 54;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 22;

    // Stream payload widths (tdata in whole bytes)
    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 160;

    // Request kinds carried on tuser
    localparam logic REQ_ACCUM = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_BINS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 1'b1;

    // One bin's statistics as held in the bin store
    typedef struct packed {
        logic [COUNT_W-1:0]  count;
        logic [SAMPLE_W-1:0] min;
        logic [SAMPLE_W-1:0] max;
        logic [SUM_W-1:0]    sum;
    } t_bin_stats;

endpackage

/* src/range_binned_statistics_top.sv */
// range_binned_statistics_top: binned sample statistics with a shared
// bit-serial divider. Depends on rbs_pkg.
//
// Usage
//   Slave stream carries requests: tuser = req_type (0 accumulate, 1 query),
//   tdata = sample_value [21:0], query_bin [27:22]. An accumulate request
//   updates count, min, max and sum of bin min(sample / bin_width,
//   num_bins - 1); samples at or above VALUE_LIMIT are dropped. A query
//   request returns one result on the master stream: count, min, max, sum,
//   mean = sum / count and an empty flag (mean 0 when empty).
//   Configuration: i_cfg_we with i_cfg_idx 0 writes num_bins, 1 writes
//   bin_width; write only while no request is in progress.
// Timing
//   One request at a time; o_s_tready is high only between requests.
//   A single restoring divider, one quotient bit per cycle, sets the pace:
//   an accumulate runs 22 divide steps, a store read and an update; a query
//   reads the store, loads the divider and divides (not for an empty bin);
//   a query outside the store or a dropped sample needs no divide.
// Reset and stalls
//   Reset clears all bins (per-bin valid flags, no sweep), num_bins = 1,
//   bin_width = 3000000. A stalled receiver holds the result in the output
//   register; the block keeps taking requests and only waits when a new
//   query result is ready while the previous one is still pending.
module range_binned_statistics_top #(
    parameter int MAX_BINS    = rbs_pkg::MAX_BINS_DEF,
    parameter int VALUE_LIMIT = rbs_pkg::VALUE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: sample_value[21:0], query_bin[27:22], zero pad[31:28]
    input  logic [rbs_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: req_type[0]
    input  logic [rbs_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    // Result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: bin_count[31:0], bin_min[53:32], bin_max[75:54],
    //        bin_sum[129:76], bin_mean[151:130], bin_empty[152], pad[159:153]
    output logic [rbs_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // Configuration write port
    input  logic                              i_cfg_we,
    input  logic [rbs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rbs_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rbs_pkg::*;

    localparam int IDX_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int CTR_W = $clog2(SAMPLE_W);
    localparam logic [CTR_W-1:0] LAST_STEP = CTR_W'(SAMPLE_W - 1);
    localparam logic [31:0] LIMIT32 = 32'(VALUE_LIMIT);
    localparam int PAD_W = OUT_TDATA_W - (COUNT_W + 3 * SAMPLE_W + SUM_W + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [NBINS_W-1:0]    r_num_bins;
    logic [BWIDTH_W-1:0]   r_bin_width;
    logic                  r_kind;
    logic [SAMPLE_W-1:0]   r_sample;
    logic [IDX_W-1:0]      r_bin;
    logic [CTR_W-1:0]      r_step;
    logic [COUNT_W-1:0]    r_rem;
    logic [SAMPLE_W-1:0]   r_dvd;
    logic [COUNT_W-1:0]    r_dsr;
    logic [MAX_BINS-1:0]   r_valid;
    t_bin_stats            r_mem [MAX_BINS];
    t_bin_stats            r_rd;
    logic                  r_rd_vld;
    t_bin_stats            r_res;
    logic                  r_empty;
    logic                  r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic                  s_fire;
    logic                  req_kind;
    logic [SAMPLE_W-1:0]   req_sample;
    logic [QBIN_W-1:0]     req_qbin;
    logic                  out_of_store;
    logic                  sample_drop;
    logic [IDX_W-1:0]      last_bin;
    logic [IDX_W-1:0]      acc_bin;
    logic [IDX_W-1:0]      rd_addr;
    logic [COUNT_W+1:0]    div_shift;
    logic [COUNT_W+1:0]    div_diff;
    logic                  div_qbit;
    logic                  div_done;
    t_bin_stats            upd;
    logic                  upd_skip;
    logic [SUM_W:0]        sum_wide;
    logic                  out_free;
    logic [SAMPLE_W-1:0]   mean;

    assign req_kind   = i_s_tuser[0];
    assign req_sample = i_s_tdata[SAMPLE_W-1:0];
    assign req_qbin   = i_s_tdata[SAMPLE_W +: QBIN_W];
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign o_s_tready = (r_state == S_IDLE);

    assign out_of_store = (32'(req_qbin) >= 32'(MAX_BINS));
    assign sample_drop  = (32'(req_sample) >= LIMIT32);

    // Highest bin in use: num_bins clamped to 1..MAX_BINS, minus one
    always_comb begin
        if (r_num_bins == '0) begin
            last_bin = '0;
        end else if (32'(r_num_bins) > 32'(MAX_BINS)) begin
            last_bin = IDX_W'(MAX_BINS - 1);
        end else begin
            last_bin = IDX_W'(32'(r_num_bins) - 32'd1);
        end
    end

    // Bin of the sample: quotient clamped to the last bin in use
    assign acc_bin = (32'(r_dvd) > 32'(last_bin)) ? last_bin : IDX_W'(r_dvd);
    assign rd_addr = (r_kind == REQ_ACCUM) ? acc_bin : r_bin;

    // Shared restoring divider, one quotient bit per step
    assign div_shift = {1'b0, r_rem, r_dvd[SAMPLE_W-1]};
    assign div_diff  = div_shift - {2'b00, r_dsr};
    assign div_qbit  = !div_diff[COUNT_W+1];
    assign div_done  = (r_step == LAST_STEP);

    // Bin update from the registered store read
    always_comb begin
        sum_wide = {1'b0, r_rd.sum} + (SUM_W + 1)'(r_sample);
        upd_skip = r_rd_vld && (r_rd.count == '1);
        if (!r_rd_vld) begin
            upd.count = COUNT_W'(1);
            upd.min   = r_sample;
            upd.max   = r_sample;
            upd.sum   = SUM_W'(r_sample);
        end else begin
            upd.count = r_rd.count + COUNT_W'(1);
            upd.min   = (r_sample < r_rd.min) ? r_sample : r_rd.min;
            upd.max   = (r_sample > r_rd.max) ? r_sample : r_rd.max;
            upd.sum   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        end
    end

    assign out_free = !r_m_valid || i_m_tready;
    assign mean     = r_empty ? '0 : r_dvd;

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if (req_kind == REQ_QUERY) begin
                        n_state = out_of_store ? S_FIN : S_RD;
                    end else if (!sample_drop) begin
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = (r_kind == REQ_ACCUM) ? S_RD : S_FIN;
                end
            end
            S_RD: begin
                n_state = (r_kind == REQ_ACCUM) ? S_UPD : S_LOAD;
            end
            S_UPD: begin
                n_state = S_IDLE;
            end
            S_LOAD: begin
                n_state = (r_rd_vld && r_rd.count != '0) ? S_DIV : S_FIN;
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_num_bins  <= NBINS_W'(1);
            r_bin_width <= BWIDTH_W'(VALUE_LIMIT_DEF);
            r_valid     <= '0;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_BINS:  r_num_bins  <= i_cfg_data[NBINS_W-1:0];
                    CFG_BIN_WIDTH: r_bin_width <= i_cfg_data[BWIDTH_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_UPD && !upd_skip) begin
                r_valid[r_bin] <= 1'b1;
            end
            if (r_state == S_FIN && out_free) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_kind   <= req_kind;
                r_sample <= req_sample;
                r_bin    <= IDX_W'(req_qbin);
                r_step   <= '0;
                // sample / bin_width, zero width taken as one
                r_rem    <= '0;
                r_dvd    <= req_sample;
                r_dsr    <= (r_bin_width == '0) ? COUNT_W'(1) : COUNT_W'(r_bin_width);
                // answer of a bin outside the store
                r_empty   <= 1'b1;
                r_res.count <= '0;
                r_res.min   <= LIMIT32[SAMPLE_W-1:0];
                r_res.max   <= '0;
                r_res.sum   <= '0;
            end
            S_DIV: begin
                r_rem  <= div_qbit ? div_diff[COUNT_W-1:0] : div_shift[COUNT_W-1:0];
                r_dvd  <= {r_dvd[SAMPLE_W-2:0], div_qbit};
                r_step <= r_step + CTR_W'(1);
            end
            S_RD: begin
                r_bin    <= rd_addr;
                r_rd     <= r_mem[rd_addr];
                r_rd_vld <= r_valid[rd_addr];
            end
            S_LOAD: begin
                // quotient fits the sample width, so the upper sum bits
                // start as the partial remainder
                r_step <= '0;
                r_rem  <= r_rd.sum[SUM_W-1:SAMPLE_W];
                r_dvd  <= r_rd.sum[SAMPLE_W-1:0];
                r_dsr  <= r_rd.count;
                if (r_rd_vld) begin
                    r_res   <= r_rd;
                    r_empty <= (r_rd.count == '0);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    r_m_data <= {PAD_W'(0), r_empty, mean, r_res.sum,
                                 r_res.max, r_res.min, r_res.count};
                end
            end
            default: ;
        endcase
    end

    // Bin store write port
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD && !upd_skip) begin
            r_mem[r_bin] <= upd;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

/* sim/tb_range_binned_statistics_top.sv */
// Self-checking testbench for range_binned_statistics_top: random stream traffic,
// a per-bin statistics predictor and a result scoreboard.
// Depends on rbs_pkg and range_binned_statistics_top.
module tb_range_binned_statistics_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rbs_pkg::*;

    localparam int              NBINS         = MAX_BINS_DEF;
    localparam int              LIMIT         = VALUE_LIMIT_DEF;
    localparam longint unsigned SUM_MAX       = (64'd1 << SUM_W) - 1;
    localparam int              SETTLE_CYCLES = 40;
    localparam int              DRAIN_LIMIT   = 20000;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              PHASE_ITEMS   = 200;

    // One bin readout as the result stream should carry it
    typedef struct packed {
        logic [COUNT_W-1:0]  cnt;
        logic [SAMPLE_W-1:0] vmin;
        logic [SAMPLE_W-1:0] vmax;
        logic [SUM_W-1:0]    total;
        logic [SAMPLE_W-1:0] mean;
        logic                empty;
    } t_report;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_s_tvalid;
    logic                    o_s_tready;
    logic [IN_TDATA_W-1:0]   i_s_tdata;
    logic [IN_TUSER_W-1:0]   i_s_tuser;
    logic                    o_m_tvalid;
    logic                    i_m_tready;
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_idx;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    range_binned_statistics_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow copy of the bin store and registers
    logic [COUNT_W-1:0]  count_mem [NBINS];
    logic [SAMPLE_W-1:0] min_mem   [NBINS];
    logic [SAMPLE_W-1:0] max_mem   [NBINS];
    logic [SUM_W-1:0]    sum_mem   [NBINS];
    logic [NBINS_W-1:0]  nbins_cfg;
    logic [BWIDTH_W-1:0] width_cfg;

    t_report pending_reports [$];

    int  errors          = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  reg_writes      = 0;
    int  settings_used   = 0;
    bit  src_idle        = 1'b1;
    bit  sink_idle       = 1'b1;
    bit  hold_request    = 1'b0;

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bins actually in use: zero reads as one, oversize clips to the store
    function automatic int unsigned bins_used();
        int unsigned n;
        n = 32'(nbins_cfg);
        if (n == 0) n = 1;
        if (n > NBINS) n = NBINS;
        return n;
    endfunction

    // Fold one sample into the shadow store
    function automatic void tally_sample(input logic [SAMPLE_W-1:0] v);
        longint unsigned w;
        longint unsigned b;
        longint unsigned s;
        w = (width_cfg == 0) ? 64'd1 : 64'(width_cfg);
        if (v >= LIMIT) return;
        b = 64'(v) / w;
        if (b > 64'(bins_used()) - 64'd1) b = 64'(bins_used()) - 64'd1;
        // saturated count: sample is dropped entirely
        if (count_mem[b] == '1) return;
        count_mem[b] = count_mem[b] + COUNT_W'(1);
        if (v > max_mem[b]) max_mem[b] = v;
        if (v < min_mem[b]) min_mem[b] = v;
        s = 64'(sum_mem[b]);
        if (s > SUM_MAX - 64'(v)) sum_mem[b] = SUM_W'(SUM_MAX);
        else sum_mem[b] = SUM_W'(s + 64'(v));
    endfunction

    // Readout of one bin, empty when outside the store
    function automatic t_report bin_report(input logic [QBIN_W-1:0] qb);
        t_report         r;
        longint unsigned q;
        r.cnt   = '0;
        r.vmin  = SAMPLE_W'(LIMIT);
        r.vmax  = '0;
        r.total = '0;
        if (qb < NBINS) begin
            r.cnt   = count_mem[qb];
            r.vmin  = min_mem[qb];
            r.vmax  = max_mem[qb];
            r.total = sum_mem[qb];
        end
        q       = (r.cnt != 0) ? (64'(r.total) / 64'(r.cnt)) : 64'd0;
        r.mean  = q[SAMPLE_W-1:0];
        r.empty = (r.cnt == 0);
        return r;
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Offer one request and hold it until accepted; valid stays high for a follow-up
    task automatic send_request(input logic kind, input logic [SAMPLE_W-1:0] smp,
                                input logic [QBIN_W-1:0] qb);
        int gap;
        if (src_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {{(IN_TDATA_W-QBIN_W-SAMPLE_W){1'b0}}, qb, smp};
        do @(posedge i_clk); while (!o_s_tready);
        requests_sent++;
        if (kind == REQ_QUERY) pending_reports.push_back(bin_report(qb));
        else tally_sample(smp);
    endtask

    // Stop offering, wait for all results, then let any accumulate finish
    task automatic quiesce();
        int waited;
        i_s_tvalid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_reports.size());
            errors++;
            pending_reports.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        if (idx == CFG_NUM_BINS) nbins_cfg = data[NBINS_W-1:0];
        else width_cfg = data[BWIDTH_W-1:0];
        reg_writes++;
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] nb,
                                  input logic [CFG_DATA_W-1:0] bw);
        quiesce();
        write_reg(CFG_NUM_BINS, nb);
        write_reg(CFG_BIN_WIDTH, bw);
        settings_used++;
    endtask

    // Mostly in-range samples, some on bin edges, some anywhere in 22 bits
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int     r;
        longint w;
        longint v;
        r = $urandom_range(0, 99);
        w = (width_cfg == 0) ? 64'd1 : 64'(width_cfg);
        if (r < 80) return SAMPLE_W'($urandom_range(0, LIMIT - 1));
        if (r < 92) begin
            v = longint'($urandom_range(0, bins_used())) * w - 1 + $urandom_range(0, 2);
            if (v < 0) v = 0;
            if (v > 64'h3FFFFF) v = 64'h3FFFFF;
            return v[SAMPLE_W-1:0];
        end
        return SAMPLE_W'($urandom);
    endfunction

    task automatic send_random();
        logic                kind;
        logic [QBIN_W-1:0]   qb;
        kind = ($urandom_range(0, 99) < 30) ? REQ_QUERY : REQ_ACCUM;
        if ($urandom_range(0, 3) != 0) qb = QBIN_W'($urandom_range(0, bins_used() - 1));
        else qb = QBIN_W'($urandom);
        send_request(kind, pick_sample(), qb);
    endtask

    // Corners: reset contents, dropped samples, zero and oversize registers
    task automatic test_directed_corners();
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd0);
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd63);
        send_request(REQ_ACCUM, 22'd0, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd2999999, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd3000000, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'h3FFFFF, QBIN_W'($urandom));
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd0);
        // zero registers read as one bin of width one
        apply_settings(22'd0, 22'd0);
        send_request(REQ_ACCUM, 22'd5, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd1, QBIN_W'($urandom));
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd0);
        // num_bins above the store clips to 64
        apply_settings(22'd127, 22'd0);
        send_request(REQ_ACCUM, 22'd100, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd63, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd10, QBIN_W'($urandom));
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd63);
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd10);
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd5);
        // bins above num_bins keep their old statistics
        apply_settings(22'd4, 22'd750000);
        send_request(REQ_ACCUM, 22'd749999, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd750000, QBIN_W'($urandom));
        send_request(REQ_ACCUM, 22'd2999999, QBIN_W'($urandom));
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd1);
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd3);
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd63);
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd40);
        // widest bin width: everything lands in bin zero
        apply_settings(22'd64, 22'h3FFFFF);
        send_request(REQ_ACCUM, 22'd2999999, QBIN_W'($urandom));
        send_request(REQ_QUERY, SAMPLE_W'($urandom), 6'd0);
    endtask

    // Long output hold while queries keep coming, so the input stalls
    task automatic test_back_pressure();
        apply_settings(22'd16, 22'd187500);
        src_idle     = 1'b0;
        sink_idle    = 1'b0;
        hold_request = 1'b1;
        repeat (8) send_request(REQ_ACCUM, pick_sample(), QBIN_W'($urandom));
        repeat (16) send_request(REQ_QUERY, SAMPLE_W'($urandom), QBIN_W'($urandom_range(0, 15)));
        quiesce();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
    endtask

    // Random traffic over several register settings; last phase without idling
    task automatic test_random_phases();
        int                  ph;
        int                  nb;
        logic [CFG_DATA_W-1:0] nb_data;
        logic [CFG_DATA_W-1:0] bw_data;
        for (ph = 0; ph < 7; ph++) begin
            nb = $urandom_range(1, NBINS);
            case (ph)
                0: begin
                    nb_data = 22'd1;
                    bw_data = 22'd3000000;
                end
                1: begin
                    nb_data = 22'd64;
                    bw_data = 22'd46875;
                end
                2: begin
                    nb_data = 22'd8;
                    bw_data = 22'd375000;
                end
                4: begin
                    nb_data = CFG_DATA_W'($urandom);
                    bw_data = CFG_DATA_W'($urandom);
                end
                5: begin
                    nb_data = 22'd64;
                    bw_data = 22'd1;
                end
                default: begin
                    nb_data = CFG_DATA_W'(nb);
                    bw_data = CFG_DATA_W'(LIMIT / nb);
                end
            endcase
            apply_settings(nb_data, bw_data);
            if (ph == 6) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end
            repeat (PHASE_ITEMS) send_random();
        end
    endtask

    // Result ready: random stalls, plus one counted long hold on request
    initial begin : sink_control
        int stretch;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_request = 1'b0;
                i_m_tready <= 1'b1;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                stretch = $urandom_range(1, 12);
                i_m_tready <= 1'b0;
                repeat (stretch) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted result with the oldest expected readout
    always @(posedge i_clk) begin : result_check
        t_report want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                results_checked++;
                compare_field("bin_count", 64'(want.cnt),   64'(o_m_tdata[31:0]));
                compare_field("bin_min",   64'(want.vmin),  64'(o_m_tdata[53:32]));
                compare_field("bin_max",   64'(want.vmax),  64'(o_m_tdata[75:54]));
                compare_field("bin_sum",   64'(want.total), 64'(o_m_tdata[129:76]));
                compare_field("bin_mean",  64'(want.mean),  64'(o_m_tdata[151:130]));
                compare_field("bin_empty", 64'(want.empty), 64'(o_m_tdata[152]));
            end
        end
    end

    // Run limit
    initial begin : watchdog
        #(5_000_000);
        $display("%0t: run limit reached", $time);
        $display("status: fail");
        $finish;
    end

    initial begin : run
        int i;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        nbins_cfg = NBINS_W'(1);
        width_cfg = BWIDTH_W'(LIMIT);
        for (i = 0; i < NBINS; i++) begin
            count_mem[i] = '0;
            min_mem[i]   = SAMPLE_W'(LIMIT);
            max_mem[i]   = '0;
            sum_mem[i]   = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_corners();
        test_back_pressure();
        test_random_phases();
        quiesce();

        $display("Covered %0d requests and checked %0d bin readouts over %0d register settings.",
                 requests_sent, results_checked, settings_used);
        $display("Included reset contents, dropped samples, zero and oversize registers, "
                 , "and a long output hold.");
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
src/rbs_pkg.sv
src/range_binned_statistics_top.sv
sim/tb_range_binned_statistics_top.sv
